### rtl/bls_pkg.sv
package bls_pkg;

	// field widths fixed by the interface
	localparam int WORD_W = 32;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;

	// capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_PEEK = 2'd2,
		REQ_TRAV = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_INDEX     = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic    wr_push;     // store push word on top, count up
		logic    rd_pop;      // read top word, count down
		logic    rd_peek;     // read at peek position
		logic    trav_first;  // read bottom word, clear walk index
		logic    trav_next;   // read next word up, advance walk index
		logic    emit;        // load result register
		status_t emit_status;
		logic    emit_mem;    // result word comes from memory read data
		logic    emit_last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic peek_bad;
		logic trav_last;
	} stat_t;

endpackage

### rtl/bls_ctrl.sv
module bls_ctrl
	import bls_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   req_type,
	input  stat_t        stat,
	output logic         busy,
	output cmd_t         cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_TRAV
	} state_t;

	state_t state_q;
	state_t state_d;
	req_t   req;

	assign req  = req_t'(req_type);
	assign busy = (state_q != S_IDLE);

	// command decode and next state
	always_comb begin
		cmd         = '0;
		cmd.emit_status = ST_OK;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req)
						REQ_PUSH: begin
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							if (stat.full) begin
								cmd.emit_status = ST_OVERFLOW;
							end else begin
								cmd.wr_push = 1'b1;
							end
						end
						default: begin
							if (stat.empty) begin
								cmd.emit        = 1'b1;
								cmd.emit_last   = 1'b1;
								cmd.emit_status = ST_UNDERFLOW;
							end else if (req == REQ_POP) begin
								cmd.rd_pop = 1'b1;
								state_d    = S_READ;
							end else if (req == REQ_PEEK) begin
								if (stat.peek_bad) begin
									cmd.emit        = 1'b1;
									cmd.emit_last   = 1'b1;
									cmd.emit_status = ST_INDEX;
								end else begin
									cmd.rd_peek = 1'b1;
									state_d     = S_READ;
								end
							end else begin
								cmd.trav_first = 1'b1;
								state_d        = S_TRAV;
							end
						end
					endcase
				end
			end
			S_READ: begin
				cmd.emit      = 1'b1;
				cmd.emit_mem  = 1'b1;
				cmd.emit_last = 1'b1;
				state_d       = S_IDLE;
			end
			S_TRAV: begin
				cmd.emit      = 1'b1;
				cmd.emit_mem  = 1'b1;
				cmd.emit_last = stat.trav_last;
				if (stat.trav_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.trav_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/bls_dpath.sv
module bls_dpath
	import bls_pkg::*;
#(
	parameter int DEPTH = 64
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_capacity,
	input  logic [WORD_W-1:0] push_value,
	input  logic [POS_W-1:0]  peek_position,
	output logic              done,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] read_value,
	output logic              last_of_run,
	output logic              is_full,
	output logic              is_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  eff_cap;
	logic [CNT_W-1:0]  count_dec;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_inc;
	logic [AW-1:0]     rd_addr;
	logic              rd_en;
	logic              done_q;
	status_t           status_q;
	logic [WORD_W-1:0] value_q;
	logic              last_q;
	logic              full_q;
	logic              empty_q;

	// capacity limited to the physical depth
	assign eff_cap   = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
	assign count_dec = count_q - CNT_W'(1);
	assign idx_inc   = idx_q + AW'(1);

	// status back to the controller
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= eff_cap);
	assign stat.peek_bad  = ({1'b0, peek_position} >= count_q) ||
	                        ({1'b0, peek_position} >= DEPTH_C);
	assign stat.trav_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// entry count after this cycle's command
	always_comb begin
		count_d = count_q;
		if (cmd.wr_push) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.rd_pop) begin
			count_d = count_dec;
		end
	end

	// read address select
	always_comb begin
		rd_en   = cmd.rd_pop | cmd.rd_peek | cmd.trav_first | cmd.trav_next;
		rd_addr = '0;
		if (cmd.rd_pop) begin
			rd_addr = count_dec[AW-1:0];
		end else if (cmd.rd_peek) begin
			rd_addr = AW'(peek_position);
		end else if (cmd.trav_next) begin
			rd_addr = idx_inc;
		end
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_push) begin
			mem[count_q[AW-1:0]] <= push_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// capacity, count and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_capacity;
			end
			count_q <= count_d;
			if (cmd.trav_first) begin
				idx_q <= '0;
			end else if (cmd.trav_next) begin
				idx_q <= idx_inc;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// result payload, flags taken from the count after the request
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			value_q  <= cmd.emit_mem ? rdata_q : '0;
			last_q   <= cmd.emit_last;
			full_q   <= (count_d >= eff_cap);
			empty_q  <= (count_d == '0);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = value_q;
	assign last_of_run = last_q;
	assign is_full     = full_q;
	assign is_empty    = empty_q;

endmodule

### rtl/bounded_lifo_stack.sv
// bounded LIFO stack of signed 32-bit words, up to DEPTH entries
// request channel: a request is taken at a clock edge with start high and
// busy low; req_type selects push, pop, peek at a position from the bottom,
// or traverse of all entries bottom to top
// result channel: each result is on the result ports for one cycle while
// done is high; the receiver cannot stall, so no back pressure exists
// results: push, and any request rejected with an error status, gives its
// result in the cycle after acceptance and busy stays low (one per cycle);
// pop and peek give their result through the registered read of the entry
// memory and then the result register, busy until the result is loaded;
// traverse of N entries gives N results on consecutive cycles, busy until
// the final one is loaded, last_of_run on the final one
// config channel: cfg_capacity is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high, write only while no request is in flight
// reset: stack empty, capacity 64, no result pending; entry memory is not
// cleared, only entries below the stored count are ever read
module bounded_lifo_stack
	import bls_pkg::*;
#(
	parameter int DEPTH = 64
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [WORD_W-1:0] push_value,
	input  logic [POS_W-1:0]  peek_position,
	output logic              done,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] read_value,
	output logic              last_of_run,
	output logic              is_full,
	output logic              is_empty,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_capacity
);

	cmd_t  cmd;
	stat_t stat;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	bls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd)
	);

	bls_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_capacity  (cfg_capacity),
		.push_value    (push_value),
		.peek_position (peek_position),
		.done          (done),
		.status        (status),
		.read_value    (read_value),
		.last_of_run   (last_of_run),
		.is_full       (is_full),
		.is_empty      (is_empty)
	);

endmodule
